>>> rtl/qvr_pkg.sv
// Shared constants for the quaternion vector rotate block.
// No dependencies; compile first.
package qvr_pkg;

  localparam int QVR_WIDTH       = 32;
  localparam int QVR_QUEUE_DEPTH = 4;

  // result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_ZERO_NORM = 2'd1;
  localparam logic [1:0] STATUS_SAT       = 2'd2;

endpackage

>>> rtl/qvr_if.sv
// Valid/ready channel interfaces for the quaternion vector rotate block.
// Depends on qvr_pkg.
interface qvr_in_if #(parameter int WIDTH = qvr_pkg::QVR_WIDTH) ();
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] quat_w;
  logic signed [WIDTH-1:0] quat_x;
  logic signed [WIDTH-1:0] quat_y;
  logic signed [WIDTH-1:0] quat_z;
  logic signed [WIDTH-1:0] vec_x;
  logic signed [WIDTH-1:0] vec_y;
  logic signed [WIDTH-1:0] vec_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
                  input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
                  output ready);
endinterface

interface qvr_out_if #(parameter int WIDTH = qvr_pkg::QVR_WIDTH) ();
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] out_x;
  logic signed [WIDTH-1:0] out_y;
  logic signed [WIDTH-1:0] out_z;
  logic signed [WIDTH-1:0] out_scalar;
  logic [1:0]              status;

  modport source (output valid, out_x, out_y, out_z, out_scalar, status, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_scalar, status, output ready);
endinterface

>>> rtl/qvr_queue.sv
// Small register FIFO between the front and back sections.
// Depends on qvr_pkg for the default depth.
module qvr_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = qvr_pkg::QVR_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [AW-1:0]     wptr;
  logic [AW-1:0]     rptr;
  logic [CW-1:0]     count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/qvr_front.sv
// Front section: input register that takes items and flags a zero quaternion.
// Depends on qvr_pkg and qvr_if.
module qvr_front #(
  parameter int WIDTH = qvr_pkg::QVR_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  qvr_in_if.sink           item,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7*WIDTH:0] out_data
);
  logic             vld;
  logic [7*WIDTH:0] data;
  logic             zero;

  // N is a sum of squares, so it is zero exactly when all four parts are
  assign zero = (item.quat_w == '0) && (item.quat_x == '0) &&
                (item.quat_y == '0) && (item.quat_z == '0);

  assign item.ready = !vld || out_ready;
  assign out_valid  = vld;
  assign out_data   = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (item.ready) begin
      vld <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      data <= {zero, item.quat_w, item.quat_x, item.quat_y, item.quat_z,
               item.vec_x, item.vec_y, item.vec_z};
    end
  end

endmodule

>>> rtl/qvr_back.sv
// Back section: product pipeline, norm, and a bit-per-stage rounding divider.
// Depends on qvr_pkg and qvr_if.
module qvr_back #(
  parameter int WIDTH = qvr_pkg::QVR_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7*WIDTH:0] in_data,
  qvr_out_if.source        result
);
  import qvr_pkg::*;

  localparam int W   = WIDTH;
  localparam int TW  = 2 * W + 2;   // first product components
  localparam int NW  = 2 * W + 1;   // squared norm
  localparam int LB  = W + 1;       // low split of t
  localparam int HW  = TW - LB;     // high split of t
  localparam int LPW = LB + 1 + W;  // low partial product
  localparam int HPW = HW + W;      // high partial product
  localparam int PRW = 3 * W + 2;   // full second product
  localparam int FW  = 3 * W + 4;   // second product components
  localparam int RW  = FW + 2;      // divider remainder
  localparam int DW  = NW + 1;      // divisor 2N
  localparam int QB  = W + 2;       // quotient bits
  localparam int NST = 7 + QB;

  // t = R * (0, v): quaternion part index and vector part index per product
  localparam int MR [12] = '{1, 2, 3, 0, 2, 3, 0, 1, 3, 0, 1, 2};
  localparam int MV [12] = '{0, 1, 2, 0, 2, 1, 1, 2, 0, 2, 1, 0};
  // f = t * conj(R): t part index and R part index per product
  localparam int PT [12] = '{0, 1, 2, 3, 0, 1, 2, 3, 0, 1, 2, 3};
  localparam int PR [12] = '{1, 0, 3, 2, 2, 3, 0, 1, 3, 2, 1, 0};

  localparam logic [QB-1:0] HALF = QB'(1) << (W - 1);

  logic                    en;
  logic [NST-1:0]          vld;
  logic signed [W-1:0]     rin [4];
  logic signed [W-1:0]     vin [3];
  logic                    in_zero;

  // stage A: products
  logic                    a_zero;
  logic signed [W-1:0]     a_r  [4];
  logic signed [2*W-1:0]   a_m  [12];
  logic signed [2*W-1:0]   a_sq [4];
  // stage B: t and N
  logic                    b_zero;
  logic signed [W-1:0]     b_r [4];
  logic signed [TW-1:0]    b_t [4];
  logic [NW-1:0]           b_n;
  // stage C: split partial products
  logic                    c_zero;
  logic [NW-1:0]           c_n;
  logic signed [LPW-1:0]   c_plo [12];
  logic signed [HPW-1:0]   c_phi [12];
  // stage D: merged products
  logic                    d_zero;
  logic [NW-1:0]           d_n;
  logic signed [PRW-1:0]   d_p [12];
  // stage E: f vector part
  logic                    e_zero;
  logic [NW-1:0]           e_n;
  logic signed [FW-1:0]    e_f [3];
  // divider pipe, index 0 written by stage F
  logic [RW-1:0]           dv_rem  [3][QB];
  logic [QB-1:0]           dv_quo  [3][QB+1];
  logic                    dv_neg  [3][QB+1];
  logic [DW-1:0]           dv_d    [QB];
  logic                    dv_zero [QB+1];
  // output register
  logic signed [W-1:0]     o_val [3];
  logic [1:0]              o_status;

  logic [FW-1:0]           mag [3];
  logic                    sat [3];
  logic signed [W-1:0]     res [3];

  assign en       = !vld[NST-1] || result.ready;
  assign in_ready = en;
  assign in_zero  = in_data[7*W];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rin[k] = in_data[(7-k)*W-1 -: W];
    end
    for (int k = 0; k < 3; k++) begin
      vin[k] = in_data[(3-k)*W-1 -: W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // A
      a_zero <= in_zero;
      for (int k = 0; k < 4; k++) begin
        a_r[k]  <= rin[k];
        a_sq[k] <= rin[k] * rin[k];
      end
      for (int k = 0; k < 12; k++) begin
        a_m[k] <= rin[MR[k]] * vin[MV[k]];
      end
      // B
      b_zero <= a_zero;
      b_r    <= a_r;
      b_t[0] <= -TW'(a_m[0]) - TW'(a_m[1]) - TW'(a_m[2]);
      b_t[1] <=  TW'(a_m[3]) + TW'(a_m[4]) - TW'(a_m[5]);
      b_t[2] <=  TW'(a_m[6]) - TW'(a_m[7]) + TW'(a_m[8]);
      b_t[3] <=  TW'(a_m[9]) + TW'(a_m[10]) - TW'(a_m[11]);
      b_n    <= NW'($unsigned(a_sq[0])) + NW'($unsigned(a_sq[1])) +
                NW'($unsigned(a_sq[2])) + NW'($unsigned(a_sq[3]));
      // C: t split so each multiply stays near W by W
      c_zero <= b_zero;
      c_n    <= b_n;
      for (int k = 0; k < 12; k++) begin
        c_plo[k] <= $signed({1'b0, b_t[PT[k]][LB-1:0]}) * b_r[PR[k]];
        c_phi[k] <= $signed(b_t[PT[k]][TW-1:LB]) * b_r[PR[k]];
      end
      // D
      d_zero <= c_zero;
      d_n    <= c_n;
      for (int k = 0; k < 12; k++) begin
        d_p[k] <= (PRW'(c_phi[k]) <<< LB) + PRW'(c_plo[k]);
      end
      // E: conj(R) signs folded in
      e_zero <= d_zero;
      e_n    <= d_n;
      e_f[0] <= -FW'(d_p[0]) + FW'(d_p[1]) - FW'(d_p[2]) + FW'(d_p[3]);
      e_f[1] <= -FW'(d_p[4]) + FW'(d_p[5]) + FW'(d_p[6]) - FW'(d_p[7]);
      e_f[2] <= -FW'(d_p[8]) - FW'(d_p[9]) + FW'(d_p[10]) + FW'(d_p[11]);
      // F: round half away from zero as (2|P| + N) / 2N
      dv_zero[0] <= e_zero;
      dv_d[0]    <= {e_n, 1'b0};
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    always_ff @(posedge clk) begin
      if (en) begin
        dv_neg[l][0] <= e_f[l][FW-1];
        dv_quo[l][0] <= '0;
        dv_rem[l][0] <= (RW'(mag[l]) << 1) + RW'(e_n);
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      mag[l] = e_f[l][FW-1] ? FW'(-e_f[l]) : FW'(e_f[l]);
    end
  end

  // restoring divider, one quotient bit per stage, MSB first
  for (genvar s = 0; s < QB; s++) begin : g_div
    localparam int B = QB - 1 - s;
    logic [RW-1:0] trial;
    assign trial = RW'(dv_d[s]) << B;

    always_ff @(posedge clk) begin
      if (en) begin
        dv_zero[s+1] <= dv_zero[s];
      end
    end

    if (s < QB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          dv_d[s+1] <= dv_d[s];
        end
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic take;
      assign take = (dv_rem[l][s] >= trial);

      always_ff @(posedge clk) begin
        if (en) begin
          dv_neg[l][s+1] <= dv_neg[l][s];
          dv_quo[l][s+1] <= {dv_quo[l][s][QB-2:0], take};
        end
      end

      if (s < QB - 1) begin : g_rem
        always_ff @(posedge clk) begin
          if (en) begin
            dv_rem[l][s+1] <= take ? dv_rem[l][s] - trial : dv_rem[l][s];
          end
        end
      end
    end
  end

  // saturate and sign
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (dv_neg[l][QB]) begin
        sat[l] = dv_quo[l][QB] > HALF;
        res[l] = sat[l] ? {1'b1, {(W-1){1'b0}}} : W'(~dv_quo[l][QB] + 1'b1);
      end else begin
        sat[l] = dv_quo[l][QB] > HALF - 1'b1;
        res[l] = sat[l] ? {1'b0, {(W-1){1'b1}}} : W'(dv_quo[l][QB]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dv_zero[QB]) begin
        for (int l = 0; l < 3; l++) begin
          o_val[l] <= '0;
        end
        o_status <= STATUS_ZERO_NORM;
      end else begin
        o_val    <= res;
        o_status <= (sat[0] || sat[1] || sat[2]) ? STATUS_SAT : STATUS_OK;
      end
    end
  end

  assign result.valid  = vld[NST-1];
  assign result.out_x  = o_val[0];
  assign result.out_y  = o_val[1];
  assign result.out_z  = o_val[2];
  // scalar of R v conj(R) is identically zero for a pure v in exact arithmetic
  assign result.out_scalar = '0;
  assign result.status = o_status;

endmodule

>>> rtl/quaternion_vector_rotate.sv
// Top level of the quaternion vector rotate block.
// Depends on qvr_pkg, qvr_if, qvr_queue, qvr_front, qvr_back.
//
// Rotates a vector v by a quaternion R: out = R (0,v) conj(R) / |R|^2,
// every part rounded to nearest (ties away from zero), in the input format.
// Channels: item (sink) carries quat_w..z and vec_x..z; result (source)
// carries out_x/y/z, out_scalar and status. A transfer happens on a rising
// edge with valid and ready both high.
// Status: OK, ZERO_NORM (all outputs zero) when R is zero, SAT when any
// part was clamped to the signed range.
// Throughput: one item per cycle while result is taken; every stage is pipelined.
// Path from item transfer to result valid: the front register loads on the
// transfer edge, then come the queue, six product/norm/rounding stages,
// WIDTH + 2 divider stages (one quotient bit each), and the output register.
// Stall: when result is held off, the whole back pipeline freezes and the
// queue fills; item ready drops only once the queue and front are full.
// Reset: synchronous, clears all valid state; nothing is pending after.
module quaternion_vector_rotate #(
  parameter int WIDTH       = qvr_pkg::QVR_WIDTH,
  parameter int QUEUE_DEPTH = qvr_pkg::QVR_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  qvr_in_if.sink    item,
  qvr_out_if.source result
);
  localparam int ENTRY_W = 7 * WIDTH + 1;

  // front to queue
  logic               fq_valid;
  logic               fq_ready;
  logic [ENTRY_W-1:0] fq_data;
  // queue to back
  logic               qb_valid;
  logic               qb_ready;
  logic [ENTRY_W-1:0] qb_data;

  qvr_front #(.WIDTH(WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .out_valid (fq_valid),
    .out_ready (fq_ready),
    .out_data  (fq_data)
  );

  qvr_queue #(.DATA_W(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  qvr_back #(.WIDTH(WIDTH)) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (qb_valid),
    .in_ready (qb_ready),
    .in_data  (qb_data),
    .result   (result)
  );

endmodule

>>> rtl/qvr_checker.sv
// Port-level checks for quaternion_vector_rotate, bound to the top level.
// Depends on qvr_pkg.
module qvr_checker #(
  parameter int WIDTH = qvr_pkg::QVR_WIDTH
) (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input logic [WIDTH-1:0] out_x,
  input logic [WIDTH-1:0] out_y,
  input logic [WIDTH-1:0] out_z,
  input logic [WIDTH-1:0] out_scalar,
  input logic [1:0]       status
);
  import qvr_pkg::*;

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == STATUS_OK || status == STATUS_ZERO_NORM ||
                   status == STATUS_SAT))
    else $error("bad status code");

  a_zero_norm: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_ZERO_NORM) |->
      (out_x == '0 && out_y == '0 && out_z == '0 && out_scalar == '0))
    else $error("zero norm result not cleared");

  a_scalar: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_scalar == '0)
    else $error("scalar part not zero");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_x) && $stable(status)))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind quaternion_vector_rotate qvr_checker #(.WIDTH(WIDTH)) u_qvr_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .out_x      (result.out_x),
  .out_y      (result.out_y),
  .out_z      (result.out_z),
  .out_scalar (result.out_scalar),
  .status     (result.status)
);
